[design/ralu_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ralu_pkg: shared types and constants for the RV32IM ALU
// Operation codes, word width and the word that travels down the divide
// cell row.
// ---------------------------------------------------------------------------
package ralu_pkg;

   localparam int XLEN = 32;
   localparam int SHW  = 5;
   localparam logic [SHW-1:0] SHIFT_MASK = 5'h1F;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_AND  = 4'd2,
      OP_OR   = 4'd3,
      OP_XOR  = 4'd4,
      OP_SLL  = 4'd5,
      OP_SRL  = 4'd6,
      OP_SRA  = 4'd7,
      OP_SLT  = 4'd8,
      OP_SLTU = 4'd9,
      OP_MUL  = 4'd10,
      OP_DIV  = 4'd11,
      OP_REM  = 4'd12,
      OP_NOP  = 4'd13
   } op_type;

   // One word in flight along the cell row.
   typedef struct packed {
      logic             valid;
      logic             is_div;    // div or rem with nonzero divisor: take the cell-row result
      logic             want_rem;
      logic             neg_res;   // negate the final magnitude
      logic             by_zero;
      logic [XLEN-1:0]  early;     // result of front-end ops / zero case
      logic [XLEN-1:0]  rem;       // partial remainder
      logic [XLEN-1:0]  quo;       // dividend bits shifting out, quotient in
      logic [XLEN-1:0]  dvs;       // divisor magnitude
   } stage_type;

endpackage
`default_nettype wire

[design/ralu_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ralu_cell: one restoring-divide step
// Retires one quotient bit and hands the word to the next cell.
// ---------------------------------------------------------------------------
module ralu_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire ralu_pkg::stage_type stage_in,
   output ralu_pkg::stage_type     stage_out
);
   import ralu_pkg::*;

   stage_type       stage_ff;
   stage_type       stage_in_w;
   logic [XLEN:0]   trial;
   logic [XLEN:0]   diff;

   always_comb begin
      trial = {stage_in.rem, stage_in.quo[XLEN-1]};
      diff  = trial - {1'b0, stage_in.dvs};
      stage_in_w = stage_in;
      if (!diff[XLEN]) begin
         stage_in_w.rem = diff[XLEN-1:0];
         stage_in_w.quo = {stage_in.quo[XLEN-2:0], 1'b1};
      end else begin
         stage_in_w.rem = trial[XLEN-1:0];
         stage_in_w.quo = {stage_in.quo[XLEN-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

[design/ralu_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ralu_front: combinational operations and divide setup
// Computes every op but mul/div/rem, and loads magnitudes for the cell row.
// Multiply is not formed here; its product is taken at the tail of the row.
// ---------------------------------------------------------------------------
module ralu_front (
   input  wire logic                         valid,
   input  wire logic [3:0]                   operation,
   input  wire logic [ralu_pkg::XLEN-1:0]    operand_a,
   input  wire logic [ralu_pkg::XLEN-1:0]    operand_b,
   output ralu_pkg::stage_type               stage_out
);
   import ralu_pkg::*;

   logic [SHW-1:0]  sh;
   logic [XLEN-1:0] res;
   logic [XLEN-1:0] mag_a;
   logic [XLEN-1:0] mag_b;
   logic            na;
   logic            nb;
   logic            is_dr;

   always_comb begin
      sh    = operand_b[SHW-1:0] & SHIFT_MASK;
      na    = operand_a[XLEN-1];
      nb    = operand_b[XLEN-1];
      mag_a = na ? (~operand_a + 1'b1) : operand_a;
      mag_b = nb ? (~operand_b + 1'b1) : operand_b;
      is_dr = 1'b0;
      case (operation)
         OP_ADD:  res = operand_a + operand_b;
         OP_SUB:  res = operand_a - operand_b;
         OP_AND:  res = operand_a & operand_b;
         OP_OR:   res = operand_a | operand_b;
         OP_XOR:  res = operand_a ^ operand_b;
         OP_SLL:  res = operand_a << sh;
         OP_SRL:  res = operand_a >> sh;
         OP_SRA:  res = XLEN'($signed(operand_a) >>> sh);
         OP_SLT:  res = {{(XLEN-1){1'b0}}, $signed(operand_a) < $signed(operand_b)};
         OP_SLTU: res = {{(XLEN-1){1'b0}}, operand_a < operand_b};
         OP_DIV: begin
            res   = '1;
            is_dr = 1'b1;
         end
         OP_REM: begin
            res   = operand_a;
            is_dr = 1'b1;
         end
         default: res = '0;
      endcase
      stage_out.valid    = valid;
      stage_out.is_div   = is_dr && (operand_b != '0);
      stage_out.want_rem = (operation == OP_REM);
      stage_out.neg_res  = (operation == OP_REM) ? na : (na ^ nb);
      stage_out.by_zero  = (operand_b == '0);
      stage_out.early    = res;
      stage_out.rem      = '0;
      stage_out.quo      = mag_a;
      stage_out.dvs      = mag_b;
   end

endmodule
`default_nettype wire

[design/rv32im_alu.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rv32im_alu: RV32IM integer execute unit
// Add/sub/logic/shift/compare, low-word multiply, signed div and rem.
// ---------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle while the output word is
// not held; each word passes the row of 32 divide cells, one quotient bit per
// cell, then the output register; all operations walk the same row so results
// stay in order. The whole row stalls only when the output word is held.
// Multiply is one 32x32 product taken from registered operands that ride
// along the row, then registered once more into the output word.
module rv32im_alu (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [3:0]                 req_operation,
   input  wire logic [ralu_pkg::XLEN-1:0]  req_operand_a,
   input  wire logic [ralu_pkg::XLEN-1:0]  req_operand_b,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [ralu_pkg::XLEN-1:0]       rsp_result
);
   import ralu_pkg::*;

   stage_type       chain [XLEN+1];
   logic            advance;
   logic            is_mul_ff  [XLEN];
   logic [XLEN-1:0] mul_a_ff   [XLEN];
   logic [XLEN-1:0] mul_b_ff   [XLEN];
   logic [XLEN-1:0] prod;
   logic [XLEN-1:0] div_res;
   logic [XLEN-1:0] res_in;
   logic            rsp_valid_ff;
   logic [XLEN-1:0] rsp_result_ff;
   stage_type       tail;

   // advance the row whenever the output word is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   ralu_front u_front (
      .valid     (req_valid),
      .operation (req_operation),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < XLEN; i++) begin : g_cell
      ralu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
      // multiply operands ride alongside the row
      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (advance) begin
               is_mul_ff[i] <= (req_operation == OP_MUL);
               mul_a_ff[i]  <= req_operand_a;
               mul_b_ff[i]  <= req_operand_b;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (advance) begin
               is_mul_ff[i] <= is_mul_ff[i-1];
               mul_a_ff[i]  <= mul_a_ff[i-1];
               mul_b_ff[i]  <= mul_b_ff[i-1];
            end
         end
      end
   end

   assign tail = chain[XLEN];

   always_comb begin
      prod    = mul_a_ff[XLEN-1] * mul_b_ff[XLEN-1];
      div_res = tail.want_rem ? tail.rem : tail.quo;
      if (tail.neg_res) begin
         div_res = ~div_res + 1'b1;
      end
      if (is_mul_ff[XLEN-1]) begin
         res_in = prod;
      end else if (tail.is_div) begin
         res_in = div_res;
      end else begin
         res_in = tail.early;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= tail.valid;
         rsp_result_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("output word changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready out of step with output stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      tail.valid && tail.by_zero |-> !tail.is_div)
      else $error("divide by zero entered the divide path");

endmodule
`default_nettype wire

[tb/rv32im_alu_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rv32im_alu_test: self-checking bench for the RV32IM execute unit
// Drives operation words through the valid/ready request port, predicts the
// result of each accepted word and checks results in order on the response
// port, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------

class alu_scoreboard;
   logic [31:0] pending_q[$];
   int          errors;

   function logic [31:0] compute(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      logic [4:0]  sh;
      logic [31:0] ma, mb, q, r;
      logic        na, nb;
      sh = b[4:0];
      na = a[31];
      nb = b[31];
      ma = na ? -a : a;
      mb = nb ? -b : b;
      case (op)
         ralu_pkg::OP_ADD:  return a + b;
         ralu_pkg::OP_SUB:  return a - b;
         ralu_pkg::OP_AND:  return a & b;
         ralu_pkg::OP_OR:   return a | b;
         ralu_pkg::OP_XOR:  return a ^ b;
         ralu_pkg::OP_SLL:  return a << sh;
         ralu_pkg::OP_SRL:  return a >> sh;
         ralu_pkg::OP_SRA:  return $unsigned($signed(a) >>> sh);
         ralu_pkg::OP_SLT:  return {31'd0, $signed(a) < $signed(b)};
         ralu_pkg::OP_SLTU: return {31'd0, a < b};
         ralu_pkg::OP_MUL:  return a * b;
         ralu_pkg::OP_DIV, ralu_pkg::OP_REM: begin
            if (b == 32'd0) return (op == ralu_pkg::OP_REM) ? a : 32'hFFFF_FFFF;
            q = ma / mb;
            r = ma % mb;
            if (op == ralu_pkg::OP_REM) return na ? -r : r;
            return (na != nb) ? -q : q;
         end
         default:           return 32'd0;
      endcase
   endfunction

   function void note_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      pending_q.push_back(compute(op, a, b));
   endfunction

   task check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
         report("result with nothing pending", got, 32'd0);
         return;
      end
      want = pending_q.pop_front();
      if (got !== want) report("result mismatch", got, want);
   endtask

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: %s: got %h want %h", $realtime, what, got, want);
   endtask
endclass

module rv32im_alu_test;
   import ralu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_operation = OP_NOP;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result;

   alu_scoreboard results = new();
   bit          hold_off;
   bit          hold_done;
   int          words_sent;

   localparam logic [31:0] EDGE_VALS [8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_001F};

   rv32im_alu u_top (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            results.note_request(req_operation, req_operand_a, req_operand_b);
         if (rsp_valid && rsp_ready) results.check_result(rsp_result);
      end
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0:       return EDGE_VALS[3'($urandom_range(0, 7))];
         1:       return $urandom_range(0, 40);
         2:       return -$urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   // Present one word and hold it until accepted.
   task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b, int gap);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (results.pending_q.size() != 0) @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      repeat (10) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (120) @(negedge clock);
            hold_off  = 1'b0;
            hold_done = 1'b1;
         end
         rsp_ready <= ($urandom_range(0, 3) != 0) || words_sent < 40;
         @(negedge clock);
      end
   end

   initial begin
      logic [3:0]  op;
      int          n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every op incl. 14/15, extremes and division corners
      for (int i = 0; i < 16; i++) send_word(4'(i), 32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_word(OP_DIV, 32'h1234_5678, 32'h0, 0);
      send_word(OP_REM, 32'h1234_5678, 32'h0, 0);
      send_word(OP_DIV, -32'd7, 32'd2, 0);
      send_word(OP_REM, -32'd7, 32'd2, 0);
      send_word(OP_REM, 32'd7, -32'd2, 0);
      send_word(OP_SLL, 32'hFFFF_FFFF, 32'hFFFF_FFE1, 0);
      send_word(OP_SRA, 32'h8000_0000, 32'h0000_003F, 0);
      send_word(OP_SLTU, 32'h0, 32'hFFFF_FFFF, 0);
      send_word(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

      // fill the row while the receiver holds off
      hold_off = 1'b1;
      while (!hold_done) begin
         send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), 0);
      end
      // pause until drained
      wait_drain();

      n = 0;
      while (n < 1000) begin
         op = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(OP_MUL, OP_REM))
                                          : 4'($urandom_range(0, 15));
         if (n > 300 && n < 400)
            send_word(op, pick_operand(), pick_operand(), 0);
         else
            send_word(op, pick_operand(), pick_operand(), pick_gap());
         n++;
      end
      wait_drain();
      repeat (60) @(negedge clock);
      if (results.errors == 0 && results.pending_q.size() == 0)
         $display("rv32im_alu_test: PASS");
      else
         $display("rv32im_alu_test: FAIL");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("rv32im_alu_test: FAIL");
      $finish;
   end
endmodule
